// File: hdl/qbavt_pkg.sv
// Shared types, constants and helper functions of the quad batch vertex transform.
package qbavt_pkg;

  localparam int unsigned CordicSteps = 17;
  localparam logic signed [31:0] Deg360 = 32'sd23592960;
  localparam logic signed [31:0] Deg180 = 32'sd11796480;
  localparam logic signed [31:0] Deg90 = 32'sd5898240;
  localparam logic signed [31:0] HalfQ = 32'sd32768;
  localparam logic signed [31:0] CordicInit = 32'sd652032874;

  localparam logic [2:0] RegOffsetX = 3'd0;
  localparam logic [2:0] RegOffsetY = 3'd1;
  localparam logic [2:0] RegScaleW = 3'd2;
  localparam logic [2:0] RegScaleH = 3'd3;
  localparam logic [2:0] RegAngle = 3'd4;

  localparam logic [5:0] UnitU = 6'b001110;
  localparam logic [5:0] UnitW = 6'b011100;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t qx;
    q_t qy;
    q_t qw;
    q_t qh;
    q_t qa;
    q_t s0;
    q_t s1;
    q_t t0;
    q_t t1;
    logic last;
    logic keep;
  } quad_t;

  function automatic logic signed [22:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0: atan_deg = 23'sd2949120;
      5'd1: atan_deg = 23'sd1740967;
      5'd2: atan_deg = 23'sd919879;
      5'd3: atan_deg = 23'sd466945;
      5'd4: atan_deg = 23'sd234379;
      5'd5: atan_deg = 23'sd117304;
      5'd6: atan_deg = 23'sd58666;
      5'd7: atan_deg = 23'sd29335;
      5'd8: atan_deg = 23'sd14668;
      5'd9: atan_deg = 23'sd7334;
      5'd10: atan_deg = 23'sd3667;
      5'd11: atan_deg = 23'sd1833;
      5'd12: atan_deg = 23'sd917;
      5'd13: atan_deg = 23'sd458;
      5'd14: atan_deg = 23'sd229;
      5'd15: atan_deg = 23'sd115;
      5'd16: atan_deg = 23'sd57;
      default: atan_deg = 23'sd0;
    endcase
  endfunction

  function automatic q_t sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -36'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // Product of two Q16.16 values with round half up.
  function automatic logic signed [35:0] qmul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd32768;
    qmul = p[51:16];
  endfunction

  // Rounded product of two full-range Q16.16 values, saturated to 32 bits.
  function automatic q_t qscale(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [47:0] r;
    p = a * b + 64'sd32768;
    r = p[63:16];
    if (r > 48'sd2147483647) qscale = 32'sh7fffffff;
    else if (r < -48'sd2147483648) qscale = 32'sh80000000;
    else qscale = r[31:0];
  endfunction

endpackage

// File: hdl/quad_batch_affine_vertex_transform.sv
// Top level of the quad batch affine vertex transform.
// Quads enter through a queue-like port (push, full); a beat is taken when push is
// high and full is low. A two-entry queue between the front end and the back end
// holds quads while the back end is busy; full rises when both entries are taken.
// Each stored quad is taken from the queue, waits for the iterative CORDIC unit on
// its angle and then builds each of its six vertices and adds it to the sums. A
// quad beyond capacity waits for the CORDIC unit and then only sets the overflow
// flag. On the last quad the back end divides the sums by the vertex count bit by
// bit, starts the CORDIC unit on the mesh angle in its last step and waits for it.
// Results leave through a queue-like port (empty, pop): one vertex is offered while
// empty is low and taken when pop is high. Each vertex is read from the store,
// scaled and rotated into its output registers before it is offered, and the next
// vertex is read only after a beat is taken; while the receiver stalls the vertex
// is held and the block waits.
// The user must write configuration through the APB port only while the block is
// idle; the block itself does not enforce this. Reset clears the control state,
// the sums, the quad count and the overflow flag, and loads the register reset
// values. The vertex and texture memories hold anything until written.
module quad_batch_affine_vertex_transform
  import qbavt_pkg::*;
#(
  parameter int MAX_QUADS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  q_t          quad_x,
  input  q_t          quad_y,
  input  q_t          quad_width,
  input  q_t          quad_height,
  input  q_t          quad_angle,
  input  q_t          tex_s0,
  input  q_t          tex_s1,
  input  q_t          tex_t0,
  input  q_t          tex_t1,
  input  logic        last_quad,
  output logic        empty,
  input  logic        pop,
  output q_t          vertex_x,
  output q_t          vertex_y,
  output q_t          vertex_s,
  output q_t          vertex_t,
  output logic        last_vertex,
  output logic        dropped_quads
);
  q_t mesh_offset_x;
  q_t mesh_offset_y;
  q_t mesh_scale_w;
  q_t mesh_scale_h;
  q_t mesh_angle;
  quad_t in_quad;
  quad_t q_data;
  logic q_valid;
  logic q_pop;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_offset_x <= '0;
      mesh_offset_y <= '0;
      mesh_scale_w <= 32'sd65536;
      mesh_scale_h <= 32'sd65536;
      mesh_angle <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegOffsetX: mesh_offset_x <= pwdata;
        RegOffsetY: mesh_offset_y <= pwdata;
        RegScaleW: mesh_scale_w <= pwdata;
        RegScaleH: mesh_scale_h <= pwdata;
        RegAngle: mesh_angle <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegOffsetX: prdata = mesh_offset_x;
      RegOffsetY: prdata = mesh_offset_y;
      RegScaleW: prdata = mesh_scale_w;
      RegScaleH: prdata = mesh_scale_h;
      RegAngle: prdata = mesh_angle;
      default: prdata = '0;
    endcase
  end

  always_comb begin
    in_quad = '{qx: quad_x, qy: quad_y, qw: quad_width, qh: quad_height,
                qa: quad_angle, s0: tex_s0, s1: tex_s1, t0: tex_t0, t1: tex_t1,
                last: last_quad, keep: 1'b0};
  end

  qbavt_front #(.MaxQuads(MAX_QUADS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_quad(in_quad),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  qbavt_back #(.MaxQuads(MAX_QUADS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .mesh_offset_x(mesh_offset_x), .mesh_offset_y(mesh_offset_y),
    .mesh_scale_w(mesh_scale_w), .mesh_scale_h(mesh_scale_h),
    .mesh_angle(mesh_angle), .empty(empty), .pop(pop),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_s(vertex_s),
    .vertex_t(vertex_t), .last_vertex(last_vertex), .dropped_quads(dropped_quads)
  );
endmodule

// File: hdl/qbavt_ram.sv
// Generic single-port-write RAM with a registered read.
module qbavt_ram #(
  parameter int Width = 64,
  parameter int Depth = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/qbavt_sincos.sv
// Iterative CORDIC unit giving cosine and sine of an angle in Q16.16 degrees.
module qbavt_sincos
  import qbavt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  q_t   angle,
  output logic done,
  output q_t   cos_q,
  output q_t   sin_q
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_RED  = 4'b0100,
    S_RUN  = 4'b1000
  } sc_state_t;

  sc_state_t state;
  logic [4:0] step;
  logic signed [31:0] r;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic neg;
  logic [16:0] hi_u;
  logic [13:0] hi_v;
  logic [27:0] hi_prod;
  logic [7:0] hi_q;
  logic [13:0] hi_v_r;
  logic [7:0] hi_q_r;
  logic [2:0] hi_lo_r;
  logic [13:0] hi_rem;
  logic signed [31:0] r_pos;
  logic signed [31:0] r_half;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  // 360 degrees is 360 whole units, so only the integer part is reduced. It is
  // offset by a multiple of 360 to make it positive, split as 8 times 45, and the
  // quotient by 45 comes from a reciprocal multiplication.
  always_comb begin
    hi_u = 17'($signed(r[31:16])) + 17'd33120;
    hi_v = hi_u[16:3];
    hi_prod = 28'(hi_v) * 28'd11651;
    hi_q = hi_prod[26:19];
    hi_rem = hi_v_r - 14'(hi_q_r) * 14'd45;
    r_pos = {7'd0, hi_rem[5:0], hi_lo_r, r[15:0]};
    r_half = (r_pos > Deg180) ? r_pos - Deg360 : r_pos;
    xs = x >>> step;
    ys = y >>> step;
    xr = (x + 34'sd8192) >>> 14;
    yr = (y + 34'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r <= angle;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          hi_v_r <= hi_v;
          hi_q_r <= hi_q;
          hi_lo_r <= hi_u[2:0];
          state <= S_RED;
        end
        S_RED: begin
          x <= 34'(CordicInit);
          y <= '0;
          step <= '0;
          if (r_half > Deg90) begin
            z <= 34'(r_half - Deg180);
            neg <= 1'b1;
          end else if (r_half < -Deg90) begin
            z <= 34'(r_half + Deg180);
            neg <= 1'b1;
          end else begin
            z <= 34'(r_half);
            neg <= 1'b0;
          end
          state <= S_RUN;
        end
        S_RUN: begin
          if (step == 5'(CordicSteps)) begin
            cos_q <= neg ? -xr[31:0] : xr[31:0];
            sin_q <= neg ? -yr[31:0] : yr[31:0];
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (z >= 0) begin
              x <= x - ys;
              y <= y + xs;
              z <= z - 34'(atan_deg(step));
            end else begin
              x <= x + ys;
              y <= y - xs;
              z <= z + 34'(atan_deg(step));
            end
            step <= step + 5'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/qbavt_front.sv
// Front end: accepts quads, applies the capacity check and queues them.
module qbavt_front
  import qbavt_pkg::*;
#(
  parameter int MaxQuads = 8
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  quad_t in_quad,
  output logic  q_valid,
  output quad_t q_data,
  input  logic  q_pop
);
  localparam int CntW = $clog2(MaxQuads + 1);

  quad_t buf0;
  quad_t buf1;
  logic [1:0] fill;
  logic [CntW-1:0] count;
  logic take;
  quad_t tagged_quad;

  assign full = (fill == 2'd2);
  assign take = push && !full;
  assign q_valid = (fill != 2'd0);
  assign q_data = buf0;

  always_comb begin
    tagged_quad = in_quad;
    tagged_quad.keep = (count < CntW'(MaxQuads));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      count <= '0;
    end else begin
      if (take) begin
        if (in_quad.last) count <= '0;
        else if (count < CntW'(MaxQuads)) count <= count + 1'b1;
      end
      case ({take, q_pop && q_valid})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) begin
      buf0 <= buf1;
      if (take && fill == 2'd1) buf0 <= tagged_quad;
      if (take && fill == 2'd2) buf1 <= tagged_quad;
    end else if (take) begin
      if (fill == 2'd0) buf0 <= tagged_quad;
      else buf1 <= tagged_quad;
    end
  end
endmodule

// File: hdl/qbavt_back.sv
// Back end: per-quad vertex build, batch store, centroid and mesh transform.
module qbavt_back
  import qbavt_pkg::*;
#(
  parameter int MaxQuads = 8
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  quad_t q_data,
  output logic  q_pop,
  input  q_t    mesh_offset_x,
  input  q_t    mesh_offset_y,
  input  q_t    mesh_scale_w,
  input  q_t    mesh_scale_h,
  input  q_t    mesh_angle,
  output logic  empty,
  input  logic  pop,
  output q_t    vertex_x,
  output q_t    vertex_y,
  output q_t    vertex_s,
  output q_t    vertex_t,
  output logic  last_vertex,
  output logic  dropped_quads
);
  localparam int NVert = 6 * MaxQuads;
  localparam int VaW = $clog2(NVert);
  localparam int QaW = (MaxQuads > 1) ? $clog2(MaxQuads) : 1;
  localparam int VcW = $clog2(NVert + 1);

  typedef enum logic [9:0] {
    B_IDLE  = 10'b0000000001,
    B_QSC   = 10'b0000000010,
    B_QVTX  = 10'b0000000100,
    B_QSUM  = 10'b0000001000,
    B_DIV   = 10'b0000010000,
    B_MSC   = 10'b0000100000,
    B_RD    = 10'b0001000000,
    B_SCL   = 10'b0010000000,
    B_ROT   = 10'b0100000000,
    B_OUT   = 10'b1000000000
  } bk_state_t;

  bk_state_t state;
  quad_t cur;
  logic sc_start;
  q_t sc_angle;
  logic sc_done;
  q_t cos_q;
  q_t sin_q;
  q_t c_r;
  q_t s_r;
  logic [2:0] k;
  logic [VaW-1:0] vidx;
  logic [QaW-1:0] qidx;
  logic [VcW-1:0] nvert;
  logic signed [47:0] sum_x;
  logic signed [47:0] sum_y;
  logic ovf;
  q_t vx_r;
  q_t vy_r;
  logic signed [47:0] rem_x;
  logic signed [47:0] rem_y;
  logic signed [47:0] quo_x;
  logic signed [47:0] quo_y;
  logic [5:0] div_step;
  logic signed [47:0] den;
  q_t cx;
  q_t cy;
  logic sign_x;
  logic sign_y;
  q_t px;
  q_t py;
  logic [63:0] vram_rd;
  logic [63:0] sram_rd;
  logic [63:0] tram_rd;
  logic vram_we;
  logic tex_we;
  logic [VaW-1:0] vram_ra;
  logic [QaW-1:0] tram_ra;
  logic [2:0] kr;
  logic [VaW-1:0] vidx_r;
  logic signed [33:0] dpx;
  logic signed [33:0] dpy;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  q_t vx_n;
  q_t vy_n;
  q_t mx_n;
  q_t my_n;
  logic [47:0] ax;
  logic [47:0] ay;
  logic [47:0] tx;
  logic [47:0] ty;

  qbavt_sincos u_sincos (
    .clk(clk), .rst(rst), .start(sc_start), .angle(sc_angle),
    .done(sc_done), .cos_q(cos_q), .sin_q(sin_q)
  );

  qbavt_ram #(.Width(64), .Depth(NVert)) u_vram (
    .clk(clk), .we(vram_we), .waddr(vidx), .wdata({vx_n, vy_n}),
    .raddr(vram_ra), .rdata(vram_rd)
  );
  qbavt_ram #(.Width(64), .Depth(MaxQuads)) u_sram (
    .clk(clk), .we(tex_we), .waddr(qidx), .wdata({cur.s0, cur.s1}),
    .raddr(tram_ra), .rdata(sram_rd)
  );
  qbavt_ram #(.Width(64), .Depth(MaxQuads)) u_tram (
    .clk(clk), .we(tex_we), .waddr(qidx), .wdata({cur.t0, cur.t1}),
    .raddr(tram_ra), .rdata(tram_rd)
  );

  assign vram_we = (state == B_QVTX);
  assign tex_we = (state == B_QVTX) && (k == 3'd0);
  assign sc_start = (state == B_IDLE && q_valid) || (state == B_DIV && div_step == 6'd48);
  assign sc_angle = (state == B_IDLE) ? q_data.qa : mesh_angle;
  assign q_pop = (state == B_IDLE) && q_valid;
  assign vram_ra = vidx;
  assign tram_ra = qidx;
  assign empty = (state != B_OUT);

  always_comb begin
    dpx = UnitU[k] ? 34'(cur.qw) : 34'sd0;
    dpy = UnitW[k] ? 34'(cur.qh) : 34'sd0;
    dx = dpx - 34'(HalfQ);
    dy = dpy - 34'(HalfQ);
    vx_n = sat32(qmul(34'(c_r), dx) - qmul(34'(s_r), dy) + 36'(HalfQ) + 36'(cur.qx));
    vy_n = sat32(qmul(34'(s_r), dx) + qmul(34'(c_r), dy) + 36'(HalfQ) + 36'(cur.qy));
    dx = 34'(px) - 34'(cx);
    dy = 34'(py) - 34'(cy);
    mx_n = sat32(qmul(34'(c_r), dx) - qmul(34'(s_r), dy) + 36'(cx) + 36'(mesh_offset_x));
    my_n = sat32(qmul(34'(s_r), dx) + qmul(34'(c_r), dy) + 36'(cy) + 36'(mesh_offset_y));
    ax = sum_x[47] ? 48'(-sum_x) : 48'(sum_x);
    ay = sum_y[47] ? 48'(-sum_y) : 48'(sum_y);
    tx = {rem_x[46:0], quo_x[47]};
    ty = {rem_y[46:0], quo_y[47]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      sum_x <= '0;
      sum_y <= '0;
      ovf <= 1'b0;
      vidx <= '0;
      qidx <= '0;
      nvert <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            k <= '0;
            state <= B_QSC;
          end
        end
        B_QSC: begin
          if (sc_done) begin
            c_r <= cos_q;
            s_r <= sin_q;
            if (cur.keep) begin
              state <= B_QVTX;
            end else begin
              ovf <= 1'b1;
              state <= cur.last ? B_DIV : B_IDLE;
              div_step <= '0;
            end
          end
        end
        B_QVTX: begin
          vx_r <= vx_n;
          vy_r <= vy_n;
          state <= B_QSUM;
        end
        B_QSUM: begin
          sum_x <= sum_x + 48'(vx_r);
          sum_y <= sum_y + 48'(vy_r);
          vidx <= vidx + 1'b1;
          nvert <= nvert + 1'b1;
          if (k == 3'd5) begin
            k <= '0;
            if (qidx != QaW'(MaxQuads - 1)) qidx <= qidx + 1'b1;
            div_step <= '0;
            state <= cur.last ? B_DIV : B_IDLE;
          end else begin
            k <= k + 3'd1;
            state <= B_QVTX;
          end
        end
        B_DIV: begin
          // Restoring division of the sums by the vertex count, one bit a cycle.
          if (div_step == 6'd0) begin
            den <= 48'(nvert);
            sign_x <= sum_x[47];
            sign_y <= sum_y[47];
            quo_x <= ax;
            quo_y <= ay;
            rem_x <= '0;
            rem_y <= '0;
            div_step <= 6'd1;
          end else if (div_step <= 6'd48) begin
            if (tx >= 48'(den)) begin
              rem_x <= tx - den;
              quo_x <= {quo_x[46:0], 1'b1};
            end else begin
              rem_x <= tx;
              quo_x <= {quo_x[46:0], 1'b0};
            end
            if (ty >= 48'(den)) begin
              rem_y <= ty - den;
              quo_y <= {quo_y[46:0], 1'b1};
            end else begin
              rem_y <= ty;
              quo_y <= {quo_y[46:0], 1'b0};
            end
            div_step <= div_step + 6'd1;
            if (div_step == 6'd48) state <= B_MSC;
          end
        end
        B_MSC: begin
          cx <= sign_x ? -quo_x[31:0] : quo_x[31:0];
          cy <= sign_y ? -quo_y[31:0] : quo_y[31:0];
          if (sc_done) begin
            c_r <= cos_q;
            s_r <= sin_q;
            vidx <= '0;
            qidx <= '0;
            k <= '0;
            state <= B_RD;
          end
        end
        B_RD: begin
          kr <= k;
          vidx_r <= vidx;
          state <= B_SCL;
        end
        B_SCL: begin
          px <= qscale(mesh_scale_w, $signed(vram_rd[63:32]));
          py <= qscale(mesh_scale_h, $signed(vram_rd[31:0]));
          vertex_s <= UnitU[kr] ? sram_rd[31:0] : sram_rd[63:32];
          vertex_t <= UnitW[kr] ? tram_rd[31:0] : tram_rd[63:32];
          state <= B_ROT;
        end
        B_ROT: begin
          vertex_x <= mx_n;
          vertex_y <= my_n;
          last_vertex <= (VcW'(vidx_r) + 1'b1 == nvert);
          dropped_quads <= ovf;
          state <= B_OUT;
        end
        B_OUT: begin
          if (pop) begin
            if (last_vertex) begin
              sum_x <= '0;
              sum_y <= '0;
              ovf <= 1'b0;
              nvert <= '0;
              vidx <= '0;
              qidx <= '0;
              state <= B_IDLE;
            end else begin
              vidx <= vidx + 1'b1;
              if (k == 3'd5) begin
                k <= '0;
                qidx <= qidx + 1'b1;
              end else begin
                k <= k + 3'd1;
              end
              state <= B_RD;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/qbavt_checker.sv
// Port-level checker of the quad batch vertex transform, bound to the top level.
module qbavt_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [31:0] vertex_x,
  input logic        last_vertex,
  input logic        dropped_quads,
  input logic        pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(vertex_x) && $stable(last_vertex)))
    else $error("stalled result beat changed");
  a_drop_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_vertex) |=> ##3 (empty || $stable(dropped_quads)))
    else $error("overflow flag changed within a batch");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("result offered twice without a new computation");
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind quad_batch_affine_vertex_transform qbavt_checker u_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .vertex_x(vertex_x),
  .last_vertex(last_vertex), .dropped_quads(dropped_quads), .pready(pready)
);
